// ----- rtl/aap_pkg.sv -----
// ----------------------------------------------------------------------------
// aap_pkg
// Shared types, codes and constants of the anchor alignment placer.
// ----------------------------------------------------------------------------
package aap_pkg;

  localparam int ANG_W      = 28;
  localparam int GUARD_BITS = 12;
  localparam int IDX_W      = 5;
  localparam int THR_W      = 15;
  localparam int DIR_W      = 16;
  localparam int YAW_W      = 16;

  localparam logic [2:0] CMD_SRC_POSE = 3'd0;
  localparam logic [2:0] CMD_SRC_APOS = 3'd1;
  localparam logic [2:0] CMD_SRC_ADIR = 3'd2;
  localparam logic [2:0] CMD_TGT_APOS = 3'd3;
  localparam logic [2:0] CMD_COMPUTE  = 3'd4;

  localparam logic REL_ADJACENT = 1'b0;
  localparam logic REL_FACING   = 1'b1;

  localparam logic [THR_W-1:0] VERT_THR_RESET = 15'd11469;

  localparam logic signed [ANG_W-1:0] DEG_90  = 28'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG_180 = 28'sd11796480;
  localparam logic signed [ANG_W-1:0] DEG_360 = 28'sd23592960;

  localparam logic signed [16:0] INV_GAIN = 17'sd39797;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_sts_t;

  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] r;
    case (idx)
      5'd0:    r = 28'sd2949120;
      5'd1:    r = 28'sd1740967;
      5'd2:    r = 28'sd919879;
      5'd3:    r = 28'sd466945;
      5'd4:    r = 28'sd234379;
      5'd5:    r = 28'sd117304;
      5'd6:    r = 28'sd58666;
      5'd7:    r = 28'sd29335;
      5'd8:    r = 28'sd14668;
      5'd9:    r = 28'sd7334;
      5'd10:   r = 28'sd3667;
      5'd11:   r = 28'sd1833;
      5'd12:   r = 28'sd917;
      5'd13:   r = 28'sd458;
      5'd14:   r = 28'sd229;
      5'd15:   r = 28'sd115;
      5'd16:   r = 28'sd57;
      5'd17:   r = 28'sd29;
      5'd18:   r = 28'sd14;
      5'd19:   r = 28'sd7;
      5'd20:   r = 28'sd4;
      5'd21:   r = 28'sd2;
      5'd22:   r = 28'sd1;
      default: r = 28'sd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/aap_if.sv -----
// ----------------------------------------------------------------------------
// aap_if
// Valid/ready channels of the anchor alignment placer.
// ----------------------------------------------------------------------------
interface aap_in_if #(parameter int COORD_WIDTH = 24) ();
  logic                          valid;
  logic                          ready;
  logic [2:0]                    command;
  logic signed [COORD_WIDTH-1:0] vec_x;
  logic signed [COORD_WIDTH-1:0] vec_y;
  logic signed [COORD_WIDTH-1:0] vec_z;
  logic signed [15:0]            angle;
  logic                          relationship;
  logic signed [COORD_WIDTH-1:0] gap;

  modport source (output valid, command, vec_x, vec_y, vec_z, angle, relationship, gap,
                  input ready);
  modport sink (input valid, command, vec_x, vec_y, vec_z, angle, relationship, gap,
                output ready);
endinterface

interface aap_out_if #(parameter int COORD_WIDTH = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] loc_x;
  logic signed [COORD_WIDTH-1:0] loc_y;
  logic signed [COORD_WIDTH-1:0] loc_z;
  logic signed [15:0]            yaw_out;

  modport source (output valid, loc_x, loc_y, loc_z, yaw_out, input ready);
  modport sink (input valid, loc_x, loc_y, loc_z, yaw_out, output ready);
endinterface

interface aap_cfg_if import aap_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- rtl/aap_cordic.sv -----
// ----------------------------------------------------------------------------
// aap_cordic
// Shared iterative CORDIC: rotation with gain correction, or atan2 vectoring.
// ----------------------------------------------------------------------------
module aap_cordic import aap_pkg::*; #(
  parameter int IN_W  = 26,
  parameter int STEPS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cordic_ctl_t             ctl_i,
  input  logic signed [IN_W-1:0]  x_i,
  input  logic signed [IN_W-1:0]  y_i,
  input  logic signed [ANG_W-1:0] ang_i,
  output cordic_sts_t             sts_o,
  output logic signed [IN_W-1:0]  x_o,
  output logic signed [IN_W-1:0]  y_o,
  output logic signed [ANG_W-1:0] ang_o
);

  localparam int W  = IN_W + GUARD_BITS + 3;
  localparam int PW = W + 17;
  localparam int HW = W - 16;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (GUARD_BITS + 15);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_RED  = 3'd1;
  localparam logic [2:0] C_ITER = 3'd2;
  localparam logic [2:0] C_LO_X = 3'd3;
  localparam logic [2:0] C_HI_X = 3'd4;
  localparam logic [2:0] C_LO_Y = 3'd5;
  localparam logic [2:0] C_HI_Y = 3'd6;
  localparam logic [2:0] C_FIN  = 3'd7;

  logic [2:0]              st_q, st_d;
  logic                    vec_q, vec_d;
  logic                    done_q, done_d;
  logic [IDX_W-1:0]        i_q, i_d;
  logic signed [W-1:0]     x_q, x_d, y_q, y_d, dx, dy, xs, ys, mul_src;
  logic signed [ANG_W-1:0] z_q, z_d, at;
  logic signed [PW-1:0]    acc_q, acc_d, prod_lo, prod_hi, rnd;
  logic signed [IN_W-1:0]  xo_q, xo_d, yo_q, yo_d;
  logic signed [HW+16:0]   hi_mul;
  logic signed [33:0]      lo_mul;

  assign xs = {{(W-IN_W-GUARD_BITS){x_i[IN_W-1]}}, x_i, {GUARD_BITS{1'b0}}};
  assign ys = {{(W-IN_W-GUARD_BITS){y_i[IN_W-1]}}, y_i, {GUARD_BITS{1'b0}}};
  assign dx = y_q >>> i_q;
  assign dy = x_q >>> i_q;
  assign at = atan_lut(i_q);

  assign mul_src = (st_q == C_LO_X || st_q == C_HI_X) ? x_q : y_q;
  assign lo_mul  = $signed({1'b0, mul_src[15:0]}) * INV_GAIN;
  assign hi_mul  = $signed(mul_src[W-1:16]) * INV_GAIN;
  assign prod_lo = PW'(lo_mul);
  assign prod_hi = {hi_mul, 16'b0};
  assign rnd     = (acc_q + HALF) >>> (GUARD_BITS + 16);

  always_comb begin
    st_d   = st_q;
    vec_d  = vec_q;
    done_d = 1'b0;
    i_d    = i_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    acc_d  = acc_q;
    xo_d   = xo_q;
    yo_d   = yo_q;
    case (st_q)
      C_IDLE: begin
        if (ctl_i.start) begin
          vec_d = ctl_i.vectoring;
          i_d   = '0;
          if (ctl_i.vectoring) begin
            if (x_i == 0 && y_i == 0) begin
              z_d    = '0;
              done_d = 1'b1;
            end else begin
              st_d = C_ITER;
              if (x_i < 0) begin
                x_d = -xs;
                y_d = -ys;
                z_d = (y_i >= 0) ? DEG_180 : -DEG_180;
              end else begin
                x_d = xs;
                y_d = ys;
                z_d = '0;
              end
            end
          end else begin
            x_d  = xs;
            y_d  = ys;
            z_d  = ang_i;
            st_d = C_RED;
          end
        end
      end
      C_RED: begin
        if (z_q > DEG_180) begin
          z_d = z_q - DEG_360;
        end else if (z_q <= -DEG_180) begin
          z_d = z_q + DEG_360;
        end else begin
          st_d = C_ITER;
          if (z_q > DEG_90) begin
            x_d = -x_q;
            y_d = -y_q;
            z_d = z_q - DEG_180;
          end else if (z_q < -DEG_90) begin
            x_d = -x_q;
            y_d = -y_q;
            z_d = z_q + DEG_180;
          end
        end
      end
      C_ITER: begin
        if (vec_q) begin
          if (y_q > 0) begin
            x_d = x_q + dx;
            y_d = y_q - dy;
            z_d = z_q + at;
          end else begin
            x_d = x_q - dx;
            y_d = y_q + dy;
            z_d = z_q - at;
          end
        end else begin
          if (z_q >= 0) begin
            x_d = x_q - dx;
            y_d = y_q + dy;
            z_d = z_q - at;
          end else begin
            x_d = x_q + dx;
            y_d = y_q - dy;
            z_d = z_q + at;
          end
        end
        i_d = i_q + 1'b1;
        if (i_q == IDX_W'(STEPS - 1)) begin
          i_d = '0;
          if (vec_q) begin
            st_d   = C_IDLE;
            done_d = 1'b1;
          end else begin
            st_d = C_LO_X;
          end
        end
      end
      C_LO_X: begin
        acc_d = prod_lo;
        st_d  = C_HI_X;
      end
      C_HI_X: begin
        acc_d = acc_q + prod_hi;
        st_d  = C_LO_Y;
      end
      C_LO_Y: begin
        xo_d  = rnd[IN_W-1:0];
        acc_d = prod_lo;
        st_d  = C_HI_Y;
      end
      C_HI_Y: begin
        acc_d = acc_q + prod_hi;
        st_d  = C_FIN;
      end
      C_FIN: begin
        yo_d   = rnd[IN_W-1:0];
        done_d = 1'b1;
        st_d   = C_IDLE;
      end
      default: st_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= C_IDLE;
      vec_q  <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      st_q   <= st_d;
      vec_q  <= vec_d;
      done_q <= done_d;
      i_q    <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    acc_q <= acc_d;
    xo_q  <= xo_d;
    yo_q  <= yo_d;
  end

  assign sts_o.busy = (st_q != C_IDLE);
  assign sts_o.done = done_q;
  assign x_o        = xo_q;
  assign y_o        = yo_q;
  assign ang_o      = z_q;

endmodule

// ----- rtl/anchor_alignment_placer.sv -----
// ----------------------------------------------------------------------------
// anchor_alignment_placer
// Places a node so that its anchor meets an anchor of a placed source node.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries commands. Load commands (source pose, source anchor position,
//   source anchor direction, target anchor position) take one transfer and
//   update the stored values on that transfer; they produce no result.
//   A compute command produces one result transfer on out_o with the placed
//   location and yaw. cfg_i writes the vertical threshold; it is always ready.
//   Throughput: one item at a time, in_i is ready only when the sequencer is
//   idle. A compute runs three CORDIC rotations and, unless the target
//   direction is vertical, two atan2 vectoring passes, all on one shared
//   CORDIC unit, then three facing products and a final sum.
//   Reset clears the stored pose to zero and the threshold to 11469.
//   The result sits in an output register; if the receiver stalls, the next
//   compute runs to completion and then waits until the register is free.
// ----------------------------------------------------------------------------
module anchor_alignment_placer import aap_pkg::*; #(
  parameter int COORD_WIDTH  = 24,
  parameter int CORDIC_STEPS = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  aap_in_if.sink   in_i,
  aap_out_if.source out_o,
  aap_cfg_if.sink  cfg_i
);

  localparam int CW = COORD_WIDTH;
  localparam int IW = CW + 2;
  localparam int SW = CW + 6;
  localparam int FW = CW + 4;
  localparam logic signed [SW-1:0] LOC_MAX = (SW'(1) <<< (CW - 1)) - SW'(1);
  localparam logic signed [SW-1:0] LOC_MIN = -(SW'(1) <<< (CW - 1));

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ROT_DIR  = 3'd1;
  localparam logic [2:0] S_VEC_SRC  = 3'd2;
  localparam logic [2:0] S_VEC_TGT  = 3'd3;
  localparam logic [2:0] S_ROT_SPOS = 3'd4;
  localparam logic [2:0] S_ROT_TPOS = 3'd5;
  localparam logic [2:0] S_FACE     = 3'd6;
  localparam logic [2:0] S_SUM      = 3'd7;

  function automatic logic signed [DIR_W-1:0] sat_dir(input logic signed [CW-1:0] v);
    logic signed [DIR_W-1:0] r;
    if (v > 32767) r = 16'sh7fff;
    else if (v < -32768) r = 16'sh8000;
    else r = v[DIR_W-1:0];
    return r;
  endfunction

  function automatic logic signed [CW-1:0] sat_loc(input logic signed [SW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > LOC_MAX) r = LOC_MAX[CW-1:0];
    else if (v < LOC_MIN) r = LOC_MIN[CW-1:0];
    else r = v[CW-1:0];
    return r;
  endfunction

  logic [2:0]                st_q, st_d;
  logic                      issued_q, issued_d;
  logic [1:0]                fcnt_q, fcnt_d;
  logic                      ovalid_q, ovalid_d;
  logic [THR_W-1:0]          thr_q;

  logic signed [CW-1:0]      sloc_x_q, sloc_y_q, sloc_z_q;
  logic signed [YAW_W-1:0]   syaw_q;
  logic signed [CW-1:0]      spos_x_q, spos_y_q, spos_z_q;
  logic signed [DIR_W-1:0]   sdir_x_q, sdir_y_q, sdir_z_q;
  logic signed [CW-1:0]      tpos_x_q, tpos_y_q, tpos_z_q;

  logic signed [DIR_W-1:0]   tdx_q, tdy_q, tdz;
  logic signed [YAW_W-1:0]   hint_q;
  logic                      facing_q, vert_q;
  logic signed [CW-1:0]      gap_q;
  logic [DIR_W:0]            tdz_abs;

  logic signed [IW-1:0]      fdx_q, fdy_q, sax_q, say_q, tax_q, tay_q;
  logic signed [ANG_W-1:0]   a1_q;
  logic signed [YAW_W-1:0]   yaw_q;
  logic signed [FW-1:0]      fx_q, fy_q, fz_q, fterm;
  logic signed [ANG_W:0]     diff;
  logic signed [ANG_W:0]     yaw_full;

  logic signed [17:0]        fsel;
  logic signed [CW+17:0]     fprod;

  logic signed [SW-1:0]      lx, ly, lz;
  logic signed [CW-1:0]      loc_x_q, loc_y_q, loc_z_q;
  logic signed [YAW_W-1:0]   yaw_out_q;

  logic                      in_fire, out_free;
  logic signed [ANG_W-1:0]   syaw_ang, yaw_ang;

  cordic_ctl_t               cctl;
  cordic_sts_t               csts;
  logic signed [IW-1:0]      cx, cy, cx_o, cy_o;
  logic signed [ANG_W-1:0]   cang, cang_o;

  aap_cordic #(
    .IN_W  (IW),
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (cctl),
    .x_i    (cx),
    .y_i    (cy),
    .ang_i  (cang),
    .sts_o  (csts),
    .x_o    (cx_o),
    .y_o    (cy_o),
    .ang_o  (cang_o)
  );

  assign in_i.ready  = (st_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_free    = !ovalid_q || out_o.ready;

  assign tdz     = sat_dir(in_i.vec_z);
  assign tdz_abs = tdz[DIR_W-1] ? 17'(-$signed({tdz[DIR_W-1], tdz})) : {1'b0, tdz};

  assign syaw_ang = {{(ANG_W-YAW_W-10){syaw_q[YAW_W-1]}}, syaw_q, 10'b0};
  assign yaw_ang  = {{(ANG_W-YAW_W-10){yaw_q[YAW_W-1]}}, yaw_q, 10'b0};

  always_comb begin
    cctl.vectoring = 1'b0;
    cx             = IW'(sdir_x_q);
    cy             = IW'(sdir_y_q);
    cang           = syaw_ang;
    case (st_q)
      S_VEC_SRC: begin
        cctl.vectoring = 1'b1;
        cx             = -fdx_q;
        cy             = -fdy_q;
      end
      S_VEC_TGT: begin
        cctl.vectoring = 1'b1;
        cx             = IW'(tdx_q);
        cy             = IW'(tdy_q);
      end
      S_ROT_SPOS: begin
        cx = IW'(spos_x_q);
        cy = IW'(spos_y_q);
      end
      S_ROT_TPOS: begin
        cx   = IW'(tpos_x_q);
        cy   = IW'(tpos_y_q);
        cang = yaw_ang;
      end
      default: ;
    endcase
    cctl.start = !issued_q && !csts.busy &&
                 (st_q == S_ROT_DIR || st_q == S_VEC_SRC || st_q == S_VEC_TGT ||
                  st_q == S_ROT_SPOS || st_q == S_ROT_TPOS);
  end

  assign diff     = {a1_q[ANG_W-1], a1_q} - {cang_o[ANG_W-1], cang_o};
  assign yaw_full = (diff + (ANG_W+1)'(512)) >>> 10;

  always_comb begin
    case (fcnt_q)
      2'd0:    fsel = fdx_q[17:0];
      2'd1:    fsel = fdy_q[17:0];
      default: fsel = 18'(sdir_z_q);
    endcase
  end
  assign fprod = fsel * gap_q;
  assign fterm = FW'((fprod + (CW+18)'(8192)) >>> 14);

  always_comb begin
    lx = SW'(sloc_x_q) + SW'(sax_q) - SW'(tax_q);
    ly = SW'(sloc_y_q) + SW'(say_q) - SW'(tay_q);
    lz = SW'(sloc_z_q) + SW'(spos_z_q) - SW'(tpos_z_q);
    if (facing_q == REL_FACING) begin
      lx = lx + SW'(fx_q);
      ly = ly + SW'(fy_q);
      lz = lz + SW'(fz_q);
    end
  end

  always_comb begin
    st_d     = st_q;
    issued_d = issued_q;
    fcnt_d   = fcnt_q;
    ovalid_d = ovalid_q;
    if (out_o.valid && out_o.ready) ovalid_d = 1'b0;
    if (cctl.start) issued_d = 1'b1;
    case (st_q)
      S_IDLE: begin
        if (in_fire && in_i.command == CMD_COMPUTE) begin
          st_d     = S_ROT_DIR;
          issued_d = 1'b0;
        end
      end
      S_ROT_DIR: begin
        if (csts.done) begin
          issued_d = 1'b0;
          st_d     = vert_q ? S_ROT_SPOS : S_VEC_SRC;
        end
      end
      S_VEC_SRC: begin
        if (csts.done) begin
          issued_d = 1'b0;
          st_d     = S_VEC_TGT;
        end
      end
      S_VEC_TGT: begin
        if (csts.done) begin
          issued_d = 1'b0;
          st_d     = S_ROT_SPOS;
        end
      end
      S_ROT_SPOS: begin
        if (csts.done) begin
          issued_d = 1'b0;
          st_d     = S_ROT_TPOS;
        end
      end
      S_ROT_TPOS: begin
        if (csts.done) begin
          issued_d = 1'b0;
          fcnt_d   = '0;
          st_d     = S_FACE;
        end
      end
      S_FACE: begin
        fcnt_d = fcnt_q + 1'b1;
        if (fcnt_q == 2'd2) begin
          fcnt_d = '0;
          st_d   = S_SUM;
        end
      end
      S_SUM: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          st_d     = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      issued_q <= 1'b0;
      fcnt_q   <= '0;
      ovalid_q <= 1'b0;
      thr_q    <= VERT_THR_RESET;
      sloc_x_q <= '0;
      sloc_y_q <= '0;
      sloc_z_q <= '0;
      syaw_q   <= '0;
      spos_x_q <= '0;
      spos_y_q <= '0;
      spos_z_q <= '0;
      sdir_x_q <= '0;
      sdir_y_q <= '0;
      sdir_z_q <= '0;
      tpos_x_q <= '0;
      tpos_y_q <= '0;
      tpos_z_q <= '0;
    end else begin
      st_q     <= st_d;
      issued_q <= issued_d;
      fcnt_q   <= fcnt_d;
      ovalid_q <= ovalid_d;
      if (cfg_i.valid && cfg_i.ready) thr_q <= cfg_i.data;
      if (in_fire) begin
        case (in_i.command)
          CMD_SRC_POSE: begin
            sloc_x_q <= in_i.vec_x;
            sloc_y_q <= in_i.vec_y;
            sloc_z_q <= in_i.vec_z;
            syaw_q   <= in_i.angle;
          end
          CMD_SRC_APOS: begin
            spos_x_q <= in_i.vec_x;
            spos_y_q <= in_i.vec_y;
            spos_z_q <= in_i.vec_z;
          end
          CMD_SRC_ADIR: begin
            sdir_x_q <= sat_dir(in_i.vec_x);
            sdir_y_q <= sat_dir(in_i.vec_y);
            sdir_z_q <= sat_dir(in_i.vec_z);
          end
          CMD_TGT_APOS: begin
            tpos_x_q <= in_i.vec_x;
            tpos_y_q <= in_i.vec_y;
            tpos_z_q <= in_i.vec_z;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.command == CMD_COMPUTE) begin
      tdx_q    <= sat_dir(in_i.vec_x);
      tdy_q    <= sat_dir(in_i.vec_y);
      hint_q   <= in_i.angle;
      facing_q <= in_i.relationship;
      gap_q    <= in_i.gap;
      vert_q   <= (tdz_abs > {2'b00, thr_q});
    end
    if (csts.done) begin
      case (st_q)
        S_ROT_DIR: begin
          fdx_q <= cx_o;
          fdy_q <= cy_o;
          if (vert_q) yaw_q <= hint_q;
        end
        S_VEC_SRC:  a1_q <= cang_o;
        S_VEC_TGT:  yaw_q <= yaw_full[YAW_W-1:0];
        S_ROT_SPOS: begin
          sax_q <= cx_o;
          say_q <= cy_o;
        end
        S_ROT_TPOS: begin
          tax_q <= cx_o;
          tay_q <= cy_o;
        end
        default: ;
      endcase
    end
    if (st_q == S_FACE) begin
      case (fcnt_q)
        2'd0:    fx_q <= fterm;
        2'd1:    fy_q <= fterm;
        default: fz_q <= fterm;
      endcase
    end
    if (st_q == S_SUM && out_free) begin
      loc_x_q   <= sat_loc(lx);
      loc_y_q   <= sat_loc(ly);
      loc_z_q   <= sat_loc(lz);
      yaw_out_q <= yaw_q;
    end
  end

  assign out_o.valid   = ovalid_q;
  assign out_o.loc_x   = loc_x_q;
  assign out_o.loc_y   = loc_y_q;
  assign out_o.loc_z   = loc_z_q;
  assign out_o.yaw_out = yaw_out_q;

`ifndef NO_ASSERTIONS
  a_compute_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.command == CMD_COMPUTE |=> st_q == S_ROT_DIR)
    else $error("compute transfer did not start the sequencer");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cctl.start |-> !csts.busy && !issued_q)
    else $error("cordic started while busy");
  a_done_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    csts.done |-> issued_q)
    else $error("cordic done without a pending operation");
  a_result_from_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(st_q) == S_SUM)
    else $error("result raised outside the final sum");
`endif

endmodule
